/* sv/long_fir_convolver_macros.svh */
// assertion helpers used by the convolver controller
`ifndef LONG_FIR_CONVOLVER_MACROS_SVH
`define LONG_FIR_CONVOLVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lfc_pkg.sv */
package lfc_pkg;

  // fixed field widths
  localparam int CFG_BITS       = 17;
  localparam int TAP_INDEX_BITS = 16;
  localparam int ACC_BITS       = 64;

  // reset value of the tap count register
  localparam logic [CFG_BITS-1:0] TAP_COUNT_RESET = 17'd65536;

  // item action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } lfc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_tap;
    logic wr_hist;
    logic clear;
    logic rd_en;
    logic rd_last;
    logic acc_clear;
    logic emit;
  } lfc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } lfc_status_t;

endpackage

/* sv/lfc_dp.sv */
module lfc_dp #(
  parameter int MAX_TAPS    = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lfc_pkg::lfc_cmd_t                     cmd,
  input  logic [$clog2(MAX_TAPS)-1:0]           tap_addr,
  input  logic [$clog2(MAX_TAPS)-1:0]           hist_addr,
  input  logic signed [SAMPLE_BITS-1:0]         value,
  input  logic                                  result_stall,
  output lfc_pkg::lfc_status_t                  status,
  output logic                                  result_valid,
  output logic signed [SAMPLE_BITS-1:0]         sample_out
);

  localparam int PB = 2 * SAMPLE_BITS;
  localparam int AB = lfc_pkg::ACC_BITS;

  logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

  logic signed [SAMPLE_BITS-1:0] wdata;
  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [PB-1:0]          prod;
  logic signed [AB-1:0]          acc;
  logic signed [AB-1:0]          shifted;
  logic [AB-SAMPLE_BITS:0]       hi_part;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                          v1;
  logic                          l1;
  logic                          v2;
  logic                          l2;
  logic                          done;

  // clearing pass writes zeros
  assign wdata = cmd.clear ? '0 : value;

  // coefficient memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_tap) begin
      tap_mem[tap_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      tap_q <= tap_mem[tap_addr];
    end
  end

  // circular delay line
  always_ff @(posedge clk) begin
    if (cmd.wr_hist) begin
      hist_mem[hist_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      hist_q <= hist_mem[hist_addr];
    end
  end

  // pipeline valid and last flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      l1   <= 1'b0;
      v2   <= 1'b0;
      l2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cmd.rd_en;
      l1   <= cmd.rd_en & cmd.rd_last;
      v2   <= v1;
      l2   <= v1 & l1;
      done <= v2 & l2;
    end
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= PB'(tap_q) * PB'(hist_q);
  end

  // accumulator, wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + AB'(prod);
    end
  end

  // shift down by the fraction bits and saturate
  always_comb begin
    shifted = acc >>> (SAMPLE_BITS - 1);
    hi_part = shifted[AB-1:SAMPLE_BITS-1];
    if ((&hi_part) || !(|hi_part)) begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end else if (acc[AB-1]) begin
      sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= sat_val;
    end
  end

  // status back to the controller
  assign status.acc_done = done;
  assign status.out_free = !result_valid || !result_stall;

endmodule

/* sv/lfc_ctrl.sv */
`include "long_fir_convolver_macros.svh"

module lfc_ctrl #(
  parameter int MAX_TAPS = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  action,
  input  logic [lfc_pkg::TAP_INDEX_BITS-1:0]    tap_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lfc_pkg::CFG_BITS-1:0]          cfg_data,
  input  lfc_pkg::lfc_status_t                  status,
  output lfc_pkg::lfc_cmd_t                     cmd,
  output logic [$clog2(MAX_TAPS)-1:0]           tap_addr,
  output logic [$clog2(MAX_TAPS)-1:0]           hist_addr
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  lfc_pkg::lfc_state_t state;
  lfc_pkg::lfc_state_t state_next;

  logic [lfc_pkg::CFG_BITS-1:0] tap_count;
  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                head;
  logic [AW-1:0]                k;
  logic [AW-1:0]                pos;
  logic [AW-1:0]                n_last;
  logic [AW-1:0]                n_last_next;
  logic [31:0]                  tc_wide;
  logic [31:0]                  act_taps;
  logic [31:0]                  act_m1;
  logic [31:0]                  idx_wide;
  logic                         load_ok;
  logic                         sample_go;
  logic                         run_last;

  // active tap count, clamped to one..MAX_TAPS
  always_comb begin
    tc_wide = 32'(tap_count);
    if (tc_wide == 32'd0) begin
      act_taps = 32'd1;
    end else if (tc_wide > 32'(MAX_TAPS)) begin
      act_taps = 32'(MAX_TAPS);
    end else begin
      act_taps = tc_wide;
    end
    act_m1      = act_taps - 32'd1;
    n_last_next = act_m1[AW-1:0];
  end

  // load range check
  assign idx_wide  = 32'(tap_index);
  assign load_ok   = idx_wide < 32'(MAX_TAPS);
  assign sample_go = (state == lfc_pkg::ST_IDLE) && item_valid
                     && (action == lfc_pkg::ACT_SAMPLE);
  assign run_last  = (k == n_last);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfc_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = lfc_pkg::ST_IDLE;
        end
      end
      lfc_pkg::ST_IDLE: begin
        if (sample_go) begin
          state_next = lfc_pkg::ST_RUN;
        end
      end
      lfc_pkg::ST_RUN: begin
        if (run_last) begin
          state_next = lfc_pkg::ST_WAIT;
        end
      end
      lfc_pkg::ST_WAIT: begin
        if (status.acc_done) begin
          state_next = lfc_pkg::ST_EMIT;
        end
      end
      lfc_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = lfc_pkg::ST_IDLE;
        end
      end
      default: state_next = lfc_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    tap_addr   = k;
    hist_addr  = pos;
    unique case (state)
      lfc_pkg::ST_CLEAR: begin
        cmd.wr_tap  = 1'b1;
        cmd.wr_hist = 1'b1;
        cmd.clear   = 1'b1;
        tap_addr    = clr_addr;
        hist_addr   = clr_addr;
      end
      lfc_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        hist_addr  = head;
        tap_addr   = idx_wide[AW-1:0];
        if (item_valid) begin
          if (action == lfc_pkg::ACT_LOAD) begin
            cmd.wr_tap = load_ok;
          end else begin
            cmd.wr_hist   = 1'b1;
            cmd.acc_clear = 1'b1;
          end
        end
      end
      lfc_pkg::ST_RUN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = run_last;
      end
      lfc_pkg::ST_WAIT: begin
        cmd = '0;
      end
      lfc_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      tap_count <= lfc_pkg::TAP_COUNT_RESET;
    end else begin
      state <= state_next;
      if (state == lfc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        tap_count <= cfg_data;
      end
      if ((state == lfc_pkg::ST_RUN) && run_last) begin
        head <= (head == LAST_ADDR) ? '0 : head + AW'(1);
      end
    end
  end

  // tap walk counters
  always_ff @(posedge clk) begin
    if (sample_go) begin
      k      <= '0;
      pos    <= head;
      n_last <= n_last_next;
    end else if (state == lfc_pkg::ST_RUN) begin
      k   <= k + AW'(1);
      pos <= (pos == '0) ? LAST_ADDR : pos - AW'(1);
    end
  end

  // checks
  `LFC_ASSERT_NOW(a_no_write_during_walk, cmd.rd_en, !cmd.wr_tap && !cmd.wr_hist, "memory write during tap walk")
  `LFC_ASSERT_NOW(a_done_only_waiting, status.acc_done, state == lfc_pkg::ST_WAIT, "sum finished outside wait state")
  `LFC_ASSERT_NOW(a_emit_needs_room, cmd.emit, status.out_free, "result emitted over an untaken beat")
  `LFC_ASSERT_NEXT(a_last_ends_walk, cmd.rd_en && cmd.rd_last, state == lfc_pkg::ST_WAIT, "tap walk did not end on last tap")

endmodule

/* sv/long_fir_convolver.sv */
// a sample beat enters the delay line, then the active taps and the history are read
// through the one read port of each memory into the single shared multiply-accumulate;
// no item is taken until the saturated sum is emitted, and a load beat gives no result
// reset: synchronous, active high; afterwards both memories are cleared, during which
// items are stalled and configuration writes are still taken
module long_fir_convolver #(
  parameter int MAX_TAPS    = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  action,
  input  logic [lfc_pkg::TAP_INDEX_BITS-1:0]    tap_index,
  input  logic signed [SAMPLE_BITS-1:0]         value,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lfc_pkg::CFG_BITS-1:0]          cfg_data
);

  localparam int AW = $clog2(MAX_TAPS);

  lfc_pkg::lfc_cmd_t    cmd;
  lfc_pkg::lfc_status_t status;
  logic [AW-1:0]        tap_addr;
  logic [AW-1:0]        hist_addr;

  // sequencing and configuration
  lfc_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .tap_index  (tap_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .status     (status),
    .cmd        (cmd),
    .tap_addr   (tap_addr),
    .hist_addr  (hist_addr)
  );

  // memories, multiply-accumulate and output register
  lfc_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .tap_addr     (tap_addr),
    .hist_addr    (hist_addr),
    .value        (value),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .sample_out   (sample_out)
  );

endmodule

/* bench/tb_long_fir_convolver.sv */
`timescale 1ns / 1ps

module tb_long_fir_convolver;

  localparam int     MAX_TAPS       = 65536;
  localparam int     SAMPLE_BITS    = 24;
  localparam int     TAP_INDEX_BITS = lfc_pkg::TAP_INDEX_BITS;
  localparam int     CFG_BITS       = lfc_pkg::CFG_BITS;
  localparam int     FRAC_BITS      = SAMPLE_BITS - 1;
  localparam longint SAT_HI         = (longint'(1) <<< FRAC_BITS) - 1;
  localparam longint SAT_LO         = -SAT_HI - 1;
  localparam int     CYCLE_LIMIT    = 2_000_000;
  localparam int     MAX_REPORTS    = 10;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // one line of the directed script
  typedef struct packed {
    row_kind_t                 kind;
    logic                      act;
    logic [TAP_INDEX_BITS-1:0] idx;
    logic [SAMPLE_BITS-1:0]    val;
    logic [CFG_BITS-1:0]       cfg;
    logic                      fixed;
    logic [SAMPLE_BITS-1:0]    want;
  } script_row_t;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  logic                          action       = lfc_pkg::ACT_SAMPLE;
  logic [TAP_INDEX_BITS-1:0]     tap_index    = '0;
  logic signed [SAMPLE_BITS-1:0] value        = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [CFG_BITS-1:0]           cfg_data     = '0;

  // shadow copy of the convolver state
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic [TAP_INDEX_BITS-1:0]     hist_head;
  logic [CFG_BITS-1:0]           tap_count_q;

  logic [SAMPLE_BITS-1:0] pending_out [$];
  int                     err_count     = 0;
  int                     cycle_count   = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  long_fir_convolver #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .tap_index    (tap_index),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_taps();
    if (tap_count_q == 0) return 1;
    if (tap_count_q > MAX_TAPS) return MAX_TAPS;
    return 32'(tap_count_q);
  endfunction

  // push a sample into the delay line and form the saturated dot product
  function automatic logic [SAMPLE_BITS-1:0] convolve_sample(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    int unsigned               n;
    logic [TAP_INDEX_BITS-1:0] pos;
    longint                    acc;
    longint                    res;
    hist_mem[hist_head] = s;
    n   = active_taps();
    pos = hist_head;
    acc = 0;
    for (int unsigned k = 0; k < n; k++) begin
      acc += longint'(coef_mem[k]) * longint'(hist_mem[pos]);
      pos = pos - TAP_INDEX_BITS'(1);
    end
    hist_head = hist_head + TAP_INDEX_BITS'(1);
    // floor shift, then clamp to the sample range
    res = acc >>> FRAC_BITS;
    if (res > SAT_HI) res = SAT_HI;
    else if (res < SAT_LO) res = SAT_LO;
    return res[SAMPLE_BITS-1:0];
  endfunction

  function automatic void update_shadow(
    input logic                      act,
    input logic [TAP_INDEX_BITS-1:0] idx,
    input logic [SAMPLE_BITS-1:0]    val,
    input logic                      fixed,
    input logic [SAMPLE_BITS-1:0]    want
  );
    logic [SAMPLE_BITS-1:0] got;
    if (act == lfc_pkg::ACT_LOAD) begin
      // a 16-bit index always lands inside tap memory
      coef_mem[idx] = val;
    end else begin
      got = convolve_sample(val);
      pending_out.push_back(fixed ? want : got);
    end
  endfunction

  function automatic script_row_t beat_row(
    input logic                      act,
    input logic [TAP_INDEX_BITS-1:0] idx,
    input logic [SAMPLE_BITS-1:0]    val,
    input logic                      fixed,
    input logic [SAMPLE_BITS-1:0]    want
  );
    script_row_t r;
    r       = '0;
    r.kind  = ROW_BEAT;
    r.act   = act;
    r.idx   = idx;
    r.val   = val;
    r.fixed = fixed;
    r.want  = want;
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_BITS-1:0] c);
    script_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.cfg  = c;
    return r;
  endfunction

  // full scale, tiny or anything in between
  function automatic logic [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // present one beat, with a random hold-off first
  task automatic send_beat(
    input logic                      act,
    input logic [TAP_INDEX_BITS-1:0] idx,
    input logic [SAMPLE_BITS-1:0]    val,
    input logic                      fixed,
    input logic [SAMPLE_BITS-1:0]    want
  );
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    tap_index  <= idx;
    value      <= val;
    do @(posedge clk); while (item_stall);
    update_shadow(act, idx, val, fixed, want);
  endtask

  // hold the sender until every result is in and the last load has settled
  task automatic drain_results();
    int unsigned settle;
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    settle = active_taps() + 8;
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [CFG_BITS-1:0] cnt);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    tap_count_q = cnt;
  endtask

  // result side: random stall and in-order compare
  always @(posedge clk) begin : result_side
    logic [SAMPLE_BITS-1:0] want;
    result_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && result_valid && !result_stall) begin
      if (pending_out.size() == 0) begin
        flag_error($sformatf("unexpected result %0d", sample_out));
      end else begin
        want = pending_out.pop_front();
        if (sample_out !== want)
          flag_error($sformatf("sample_out expected %0d got %0d",
                               $signed(want), sample_out));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_long_fir_convolver: errors");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t               script [$];
    logic [TAP_INDEX_BITS-1:0] idx;

    // shadow state matches the block after reset
    foreach (hist_mem[i]) begin
      hist_mem[i] = '0;
      coef_mem[i] = '0;
    end
    hist_head   = '0;
    tap_count_q = lfc_pkg::TAP_COUNT_RESET;

    // all taps zero after reset, full length
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h7FFFFF, 1'b1, 24'h000000));
    // minus one times minus one clamps high
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h0000, 24'h800000, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'hFFFF, 24'h7FFFFF, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'hFFFF, 24'h800000, 1'b1, 24'h7FFFFF));
    // single tap
    script.push_back(cfg_row(17'd1));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h7FFFFF, 1'b0, '0));
    // two near-unity taps, then two full negative samples clamp low
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h0001, 24'h7FFFFF, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h0000, 24'h7FFFFF, 1'b0, '0));
    script.push_back(cfg_row(17'd2));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h800000, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h800000, 1'b1, 24'h800000));
    // zero count acts as one tap; floor rounding on small values
    script.push_back(cfg_row(17'd0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h000005, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'hFFFFFD, 1'b0, '0));
    // count beyond the memory saturates to full length
    script.push_back(cfg_row(17'h1FFFF));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h000001, 1'b0, '0));
    // short response, mixed taps
    script.push_back(cfg_row(17'd16));
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h0002, 24'h123456, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h000F, 24'hFEDCBA, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_LOAD,   16'h0000, 24'h400000, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h0003E8, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'hFFFC18, 1'b0, '0));
    script.push_back(beat_row(lfc_pkg::ACT_SAMPLE, 16'h0000, 24'h7FFFFF, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_tap_count(script[i].cfg);
      else
        send_beat(script[i].act, script[i].idx, script[i].val, script[i].fixed,
                  script[i].want);
    end

    // random beats in three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
      write_tap_count(CFG_BITS'($urandom_range(1, 48)));
      for (int j = 0; j < 27; j++) begin
        if (j == 13) drain_results();
        if ($urandom_range(3) == 0) begin
          // mostly taps inside the active length, now and then anywhere
          idx = ($urandom_range(7) == 0) ? TAP_INDEX_BITS'($urandom)
                                         : TAP_INDEX_BITS'($urandom_range(0, active_taps() - 1));
          send_beat(lfc_pkg::ACT_LOAD, idx, pick_value(), 1'b0, '0);
        end else begin
          send_beat(lfc_pkg::ACT_SAMPLE, TAP_INDEX_BITS'($urandom), pick_value(), 1'b0, '0);
        end
      end
    end

    drain_results();
    if (err_count == 0)
      $display("tb_long_fir_convolver: clean");
    else
      $display("tb_long_fir_convolver: errors");
    $finish;
  end

endmodule
